// ===== hdl/ray_sphere_intersection_unit_assert.svh =====
// Assertion macros shared by the ray/sphere intersection unit
`ifndef RAY_SPHERE_INTERSECTION_UNIT_ASSERT_SVH
`define RAY_SPHERE_INTERSECTION_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define RSI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define RSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rsi_pkg.sv =====
// Types, widths and register codes of the ray/sphere intersection unit
package rsi_pkg;

  // coordinate format
  localparam int COORD_W       = 32;
  localparam int FRAC_BITS_DEF = 16;

  // exact intermediate widths
  localparam int A_W    = 2 * COORD_W;      // D.D, unsigned
  localparam int B_W    = 2 * COORD_W + 2;  // D.L, signed
  localparam int C_W    = 2 * COORD_W + 3;  // L.L - r*r, signed
  localparam int MUL_W  = C_W;              // operand width of the wide multipliers
  localparam int DISC_W = 4 * COORD_W + 4;  // B*B - A*C, signed

  // wide multiplier: one chunk of the second operand per stage
  localparam int MUL_CHUNK = 16;
  localparam int MUL_LAT   = (MUL_W + MUL_CHUNK - 1) / MUL_CHUNK;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd3;

  // input beat
  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
  } ray_in_t;

  // result beat
  typedef struct packed {
    logic                 hit;
    logic [COORD_W-2:0]   distance;
  } ray_out_t;

  // sideband carried through the square-root pipeline
  typedef struct packed {
    logic                  miss;
    logic [A_W-1:0]        a;
    logic signed [B_W-1:0] b;
  } sq_side_t;

endpackage

// ===== hdl/ray_sphere_intersection_unit.sv =====
// Ray/sphere intersection: nearest non-negative root of the ray quadratic
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_ready    | in_data   (ray_in_t)
//  out     | output    | out_valid / out_ready  | out_data  (ray_out_t)
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One ray per clock while the skid register is not full. The square-root pipeline
// (one root bit per stage) and the divider (one quotient bit per stage) set the depth.
// rst_n is synchronous; it clears all valid bits and loads the sphere registers.
// The pipeline moves as one; a skid register behind the output register keeps
// accepting while a result waits, and stalls the pipeline only once it is full.
`include "ray_sphere_intersection_unit_assert.svh"
module ray_sphere_intersection_unit import rsi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ray_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ray_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  localparam int SQ_W  = (DISC_W - 1 + 2 * FRAC_BITS + 1) / 2;
  localparam int M_W   = 2 * SQ_W;
  localparam int NB_W  = B_W + FRAC_BITS;
  localparam int N_W   = ((NB_W > SQ_W + 1) ? NB_W : SQ_W + 1) + 1;
  localparam int NU_W  = N_W - 1;
  localparam logic [COORD_W-2:0] RAD_RESET = (COORD_W-1)'(1) << FRAC_BITS;

  // sphere registers
  logic signed [COORD_W-1:0] cx_r, cy_r, cz_r;
  logic [COORD_W-2:0]        rad_r;

  logic adv;

  // coefficient stage outputs
  logic                  coef_v;
  logic [A_W-1:0]        coef_a;
  logic signed [B_W-1:0] coef_b;
  logic signed [C_W-1:0] coef_c;

  // multiplier outputs and aligned A, B
  logic                      bb_v, ac_v;
  logic signed [2*MUL_W-1:0] bb_p, ac_p;
  logic [A_W-1:0]            dly_a_r [MUL_LAT];
  logic signed [B_W-1:0]     dly_b_r [MUL_LAT];

  // discriminant stage
  logic signed [2*MUL_W-1:0] disc_full;
  logic signed [DISC_W-1:0]  disc;
  logic                      disc_miss;
  logic                      ds_v_r;
  logic [M_W-1:0]            ds_m_r;
  sq_side_t                  ds_side_r;
  sq_side_t                  ds_side_nxt;

  // square root outputs
  logic            sq_v;
  logic [SQ_W-1:0] sq_root;
  logic            sq_exact;
  sq_side_t        sq_side;

  // numerator stage
  logic signed [N_W-1:0] nb;
  logic                  nv_r, nmiss_r;
  logic [A_W-1:0]        na_r;
  logic signed [N_W-1:0] n0_r, n1_r;

  // root select stage
  logic            pv_r, phit_r;
  logic [A_W-1:0]  pa_r;
  logic [NU_W-1:0] pn_r;
  logic            phit_nxt;
  logic [NU_W-1:0] pn_nxt;

  // divider and output
  logic     div_v;
  ray_out_t div_res;
  logic     out_valid_r, out_valid_nxt;
  logic     skid_v_r, skid_v_nxt;
  ray_out_t out_data_r, out_data_nxt;
  ray_out_t skid_d_r;
  logic     take_out;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      cz_r  <= '0;
      rad_r <= RAD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER_X: cx_r  <= cfg_data;
        REG_CENTER_Y: cy_r  <= cfg_data;
        REG_CENTER_Z: cz_r  <= cfg_data;
        REG_RADIUS:   rad_r <= cfg_data[COORD_W-2:0];
        default: ;
      endcase
    end
  end

  // whole pipeline steps unless the skid register is full
  assign adv      = !skid_v_r;
  assign in_ready = adv;

  rsi_coef u_coef (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (in_valid),
    .ray_i (in_data),
    .cx_i  (cx_r),
    .cy_i  (cy_r),
    .cz_i  (cz_r),
    .rad_i (rad_r),
    .vld_o (coef_v),
    .a_o   (coef_a),
    .b_o   (coef_b),
    .c_o   (coef_c)
  );

  // B*B and A*C
  rsi_mul #(.WA(MUL_W), .WB(MUL_W), .K(MUL_CHUNK)) u_mul_bb (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (coef_v),
    .a_i   (MUL_W'(coef_b)),
    .b_i   (MUL_W'(coef_b)),
    .vld_o (bb_v),
    .p_o   (bb_p)
  );

  rsi_mul #(.WA(MUL_W), .WB(MUL_W), .K(MUL_CHUNK)) u_mul_ac (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (coef_v),
    .a_i   (MUL_W'(coef_c)),
    .b_i   (MUL_W'($signed({1'b0, coef_a}))),
    .vld_o (ac_v),
    .p_o   (ac_p)
  );

  // carry A and B alongside the multipliers
  always_ff @(posedge clk) begin
    if (adv) begin
      dly_a_r[0] <= coef_a;
      dly_b_r[0] <= coef_b;
      for (int j = 1; j < MUL_LAT; j++) begin
        dly_a_r[j] <= dly_a_r[j-1];
        dly_b_r[j] <= dly_b_r[j-1];
      end
    end
  end

  // discriminant, miss on negative disc or zero direction
  always_comb begin
    disc_full        = bb_p - ac_p;
    disc             = disc_full[DISC_W-1:0];
    disc_miss        = disc[DISC_W-1] || (dly_a_r[MUL_LAT-1] == '0);
    ds_side_nxt.miss = disc_miss;
    ds_side_nxt.a    = dly_a_r[MUL_LAT-1];
    ds_side_nxt.b    = dly_b_r[MUL_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ds_v_r <= 1'b0;
    end else if (adv) begin
      ds_v_r <= bb_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds_m_r    <= disc_miss ? '0 : (M_W'(disc[DISC_W-2:0]) << (2 * FRAC_BITS));
      ds_side_r <= ds_side_nxt;
    end
  end

  rsi_sqrt #(.SQ_W(SQ_W)) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .vld_i   (ds_v_r),
    .m_i     (ds_m_r),
    .side_i  (ds_side_r),
    .vld_o   (sq_v),
    .root_o  (sq_root),
    .exact_o (sq_exact),
    .side_o  (sq_side)
  );

  // numerators: -B*2^F minus the ceiling root, plus the floor root
  assign nb = -(N_W'(sq_side.b) <<< FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 1'b0;
    end else if (adv) begin
      nv_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nmiss_r <= sq_side.miss;
      na_r    <= sq_side.a;
      n0_r    <= nb - N_W'(sq_root) - N_W'(!sq_exact);
      n1_r    <= nb + N_W'(sq_root);
    end
  end

  // nearest non-negative root
  always_comb begin
    phit_nxt = 1'b0;
    pn_nxt   = '0;
    if (!nmiss_r) begin
      if (!n0_r[N_W-1]) begin
        phit_nxt = 1'b1;
        pn_nxt   = n0_r[NU_W-1:0];
      end else if (!n1_r[N_W-1]) begin
        phit_nxt = 1'b1;
        pn_nxt   = n1_r[NU_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (adv) begin
      pv_r <= nv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      phit_r <= phit_nxt;
      pn_r   <= pn_nxt;
      pa_r   <= na_r;
    end
  end

  rsi_div #(.NU_W(NU_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (pv_r),
    .hit_i (phit_r),
    .n_i   (pn_r),
    .a_i   (pa_r),
    .vld_o (div_v),
    .res_o (div_res)
  );

  // output register with skid
  assign take_out = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    skid_v_nxt    = skid_v_r;
    out_data_nxt  = out_data_r;
    if (!take_out) begin
      if (adv && div_v) begin
        skid_v_nxt = 1'b1;
      end
    end else if (skid_v_r) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = skid_d_r;
      skid_v_nxt    = 1'b0;
    end else begin
      out_valid_nxt = adv && div_v;
      out_data_nxt  = div_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_v_r    <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (!skid_v_r) begin
      skid_d_r <= div_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `RSI_ASSERT_IMPL(a_mul_vld_match, 1'b1, bb_v == ac_v, "multiplier valids out of step")
  `RSI_ASSERT_IMPL(a_skid_needs_out, skid_v_r, out_valid_r, "skid full, output empty")
  `RSI_ASSERT_NEXT(a_skid_fill, out_valid_r && !out_ready && adv && div_v, skid_v_r, "beat lost")
  `RSI_ASSERT_IMPL(a_miss_zero, out_valid_r && !out_data_r.hit, out_data_r.distance == '0, "miss")

endmodule

// ===== hdl/rsi_coef.sv =====
// Quadratic coefficients A, B, C from the ray and the sphere, three stages
module rsi_coef import rsi_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      vld_i,
  input  ray_in_t                   ray_i,
  input  logic signed [COORD_W-1:0] cx_i,
  input  logic signed [COORD_W-1:0] cy_i,
  input  logic signed [COORD_W-1:0] cz_i,
  input  logic [COORD_W-2:0]        rad_i,
  output logic                      vld_o,
  output logic [A_W-1:0]            a_o,
  output logic signed [B_W-1:0]     b_o,
  output logic signed [C_W-1:0]     c_o
);

  logic [2:0] vld_r;

  logic signed [COORD_W-1:0] org   [3];
  logic signed [COORD_W-1:0] dir   [3];
  logic signed [COORD_W-1:0] ctr   [3];

  logic signed [COORD_W-1:0]   d_r  [3];
  logic signed [COORD_W:0]     l_r  [3];
  logic signed [2*COORD_W-1:0] dd_r [3];
  logic signed [2*COORD_W:0]   dl_r [3];
  logic signed [2*COORD_W+1:0] ll_r [3];
  logic [2*COORD_W-3:0]        rr_r;

  logic [A_W-1:0]        a_r;
  logic signed [B_W-1:0] b_r;
  logic signed [C_W-1:0] c_r;

  // unpack the beat per axis
  always_comb begin
    org[0] = ray_i.origin_x;
    org[1] = ray_i.origin_y;
    org[2] = ray_i.origin_z;
    dir[0] = ray_i.dir_x;
    dir[1] = ray_i.dir_y;
    dir[2] = ray_i.dir_z;
    ctr[0] = cx_i;
    ctr[1] = cy_i;
    ctr[2] = cz_i;
  end

  // valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  // stage 1: L = O - P; stage 2: products; stage 3: sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d_r[k]  <= dir[k];
        l_r[k]  <= (COORD_W+1)'(org[k]) - (COORD_W+1)'(ctr[k]);
        dd_r[k] <= d_r[k] * d_r[k];
        dl_r[k] <= d_r[k] * l_r[k];
        ll_r[k] <= l_r[k] * l_r[k];
      end
      rr_r <= rad_i * rad_i;
      a_r  <= A_W'($unsigned(dd_r[0])) + A_W'($unsigned(dd_r[1]))
            + A_W'($unsigned(dd_r[2]));
      b_r  <= B_W'(dl_r[0]) + B_W'(dl_r[1]) + B_W'(dl_r[2]);
      c_r  <= C_W'(ll_r[0]) + C_W'(ll_r[1]) + C_W'(ll_r[2]) - C_W'(rr_r);
    end
  end

  assign vld_o = vld_r[2];
  assign a_o   = a_r;
  assign b_o   = b_r;
  assign c_o   = c_r;

endmodule

// ===== hdl/rsi_mul.sv =====
// Pipelined signed multiplier, one chunk of the second operand per stage
module rsi_mul import rsi_pkg::*; #(
  parameter int WA = MUL_W,
  parameter int WB = MUL_W,
  parameter int K  = MUL_CHUNK
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   vld_i,
  input  logic signed [WA-1:0]   a_i,
  input  logic signed [WB-1:0]   b_i,
  output logic                   vld_o,
  output logic signed [WA+WB-1:0] p_o
);

  localparam int NCH = (WB + K - 1) / K;
  localparam int BX  = NCH * K;
  localparam int PW  = WA + WB;

  logic [NCH-1:0] vld_r;

  logic signed [WA-1:0] a_r     [NCH];
  logic signed [BX-1:0] b_r     [NCH];
  logic signed [PW-1:0] acc_r   [NCH];

  logic signed [WA-1:0] a_src   [NCH];
  logic signed [BX-1:0] b_src   [NCH];
  logic signed [PW-1:0] acc_src [NCH];
  logic signed [K:0]    dig     [NCH];
  logic signed [WA+K:0] pp      [NCH];
  logic signed [PW-1:0] acc_nxt [NCH];

  // each stage adds a times one chunk; the top chunk carries the sign
  always_comb begin
    a_src[0]   = a_i;
    b_src[0]   = BX'(b_i);
    acc_src[0] = '0;
    for (int j = 1; j < NCH; j++) begin
      a_src[j]   = a_r[j-1];
      b_src[j]   = b_r[j-1];
      acc_src[j] = acc_r[j-1];
    end
    for (int j = 0; j < NCH; j++) begin
      if (j == NCH - 1) begin
        dig[j] = {b_src[j][j*K+K-1], b_src[j][j*K +: K]};
      end else begin
        dig[j] = {1'b0, b_src[j][j*K +: K]};
      end
      pp[j]      = a_src[j] * dig[j];
      acc_nxt[j] = acc_src[j] + (PW'(pp[j]) <<< (j * K));
    end
  end

  // valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int j = 1; j < NCH; j++) begin
        vld_r[j] <= vld_r[j-1];
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NCH; j++) begin
        a_r[j]   <= a_src[j];
        b_r[j]   <= b_src[j];
        acc_r[j] <= acc_nxt[j];
      end
    end
  end

  assign vld_o = vld_r[NCH-1];
  assign p_o   = acc_r[NCH-1];

endmodule

// ===== hdl/rsi_sqrt.sv =====
// Pipelined integer square root, one root bit per stage
module rsi_sqrt import rsi_pkg::*; #(
  parameter int SQ_W = 82
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_i,
  input  logic [2*SQ_W-1:0]   m_i,
  input  sq_side_t            side_i,
  output logic                vld_o,
  output logic [SQ_W-1:0]     root_o,
  output logic                exact_o,
  output sq_side_t            side_o
);

  localparam int RW = SQ_W + 3;

  logic [SQ_W-1:0] vld_r;

  logic [2*SQ_W-1:0] m_r      [SQ_W];
  logic [SQ_W-1:0]   q_r      [SQ_W];
  logic [RW-1:0]     rem_r    [SQ_W];
  sq_side_t          side_r   [SQ_W];

  logic [2*SQ_W-1:0] m_src    [SQ_W];
  logic [SQ_W-1:0]   q_src    [SQ_W];
  logic [RW-1:0]     rem_src  [SQ_W];
  sq_side_t          side_src [SQ_W];
  logic [RW-1:0]     rem_sh   [SQ_W];
  logic [RW-1:0]     trial    [SQ_W];
  logic              ge       [SQ_W];
  logic [RW-1:0]     rem_nxt  [SQ_W];
  logic [SQ_W-1:0]   q_nxt    [SQ_W];

  // restoring digit step: bring down two bits, try (4q + 1)
  always_comb begin
    m_src[0]    = m_i;
    q_src[0]    = '0;
    rem_src[0]  = '0;
    side_src[0] = side_i;
    for (int s = 1; s < SQ_W; s++) begin
      m_src[s]    = m_r[s-1];
      q_src[s]    = q_r[s-1];
      rem_src[s]  = rem_r[s-1];
      side_src[s] = side_r[s-1];
    end
    for (int s = 0; s < SQ_W; s++) begin
      rem_sh[s]  = {rem_src[s][RW-3:0], m_src[s][2*SQ_W-1 -: 2]};
      trial[s]   = RW'({q_src[s], 2'b01});
      ge[s]      = (rem_sh[s] >= trial[s]);
      rem_nxt[s] = ge[s] ? (rem_sh[s] - trial[s]) : rem_sh[s];
      q_nxt[s]   = {q_src[s][SQ_W-2:0], ge[s]};
    end
  end

  // valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int s = 1; s < SQ_W; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < SQ_W; s++) begin
        m_r[s]    <= m_src[s] << 2;
        q_r[s]    <= q_nxt[s];
        rem_r[s]  <= rem_nxt[s];
        side_r[s] <= side_src[s];
      end
    end
  end

  assign vld_o   = vld_r[SQ_W-1];
  assign root_o  = q_r[SQ_W-1];
  assign exact_o = (rem_r[SQ_W-1] == '0);
  assign side_o  = side_r[SQ_W-1];

endmodule

// ===== hdl/rsi_div.sv =====
// Pipelined saturating divider floor(n / a): a saturation check stage, then one quotient bit per stage
module rsi_div import rsi_pkg::*; #(
  parameter int NU_W = 83
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic              hit_i,
  input  logic [NU_W-1:0]   n_i,
  input  logic [A_W-1:0]    a_i,
  output logic              vld_o,
  output ray_out_t          res_o
);

  localparam int QB  = COORD_W - 1;
  localparam int NST = QB + 1;
  localparam int CW  = (NU_W > A_W + QB) ? NU_W : A_W + QB;

  logic [NST-1:0] vld_r;

  logic [NU_W-1:0] rem_r   [NST];
  logic [QB-1:0]   q_r     [NST];
  logic [A_W-1:0]  a_r     [NST];
  logic            sat_r   [NST];
  logic            hit_r   [NST];

  logic [NU_W-1:0] rem_src [NST];
  logic [QB-1:0]   q_src   [NST];
  logic [A_W-1:0]  a_src   [NST];
  logic            sat_src [NST];
  logic            hit_src [NST];
  logic [CW-1:0]   sub     [NST];
  logic            ge      [NST];
  logic [NU_W-1:0] rem_nxt [NST];
  logic [QB-1:0]   q_nxt   [NST];
  logic            sat_nxt [NST];

  // first stage checks saturation, the rest subtract a << i
  always_comb begin
    rem_src[0] = n_i;
    q_src[0]   = '0;
    a_src[0]   = a_i;
    sat_src[0] = 1'b0;
    hit_src[0] = hit_i;
    for (int s = 1; s < NST; s++) begin
      rem_src[s] = rem_r[s-1];
      q_src[s]   = q_r[s-1];
      a_src[s]   = a_r[s-1];
      sat_src[s] = sat_r[s-1];
      hit_src[s] = hit_r[s-1];
    end
    for (int s = 0; s < NST; s++) begin
      if (s == 0) begin
        sub[s] = CW'(a_src[s]) << QB;
      end else begin
        sub[s] = CW'(a_src[s]) << (QB - s);
      end
      ge[s] = (sub[s] <= CW'(rem_src[s]));
      if (s == 0) begin
        rem_nxt[s] = rem_src[s];
        q_nxt[s]   = q_src[s];
        sat_nxt[s] = ge[s];
      end else begin
        rem_nxt[s] = ge[s] ? (rem_src[s] - sub[s][NU_W-1:0]) : rem_src[s];
        q_nxt[s]   = {q_src[s][QB-2:0], ge[s]};
        sat_nxt[s] = sat_src[s];
      end
    end
  end

  // valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int s = 1; s < NST; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NST; s++) begin
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
        a_r[s]   <= a_src[s];
        sat_r[s] <= sat_nxt[s];
        hit_r[s] <= hit_src[s];
      end
    end
  end

  // clamp on overflow, zero on a miss
  always_comb begin
    res_o.hit = hit_r[NST-1];
    if (!hit_r[NST-1]) begin
      res_o.distance = '0;
    end else if (sat_r[NST-1]) begin
      res_o.distance = '1;
    end else begin
      res_o.distance = q_r[NST-1];
    end
  end

  assign vld_o = vld_r[NST-1];

endmodule
